### hdl/glwde_pkg.sv
// Shared types and constants for the grouped low-bit weight dot engine.
package glwde_pkg;

    localparam int LANES_DEF    = 16;
    localparam int ACC_BITS_DEF = 48;
    localparam int WORD_BITS    = 32;
    localparam int CODE_BITS    = 4;
    localparam int CODES_WIDE   = WORD_BITS / 4;   // lanes fed in 4-bit mode
    localparam int DATA_BITS    = 16;
    localparam int DQ_MUL_BITS  = CODE_BITS + 1 + DATA_BITS;
    localparam int DQ_BITS      = DQ_MUL_BITS + 1;
    localparam int PROD_BITS    = DQ_BITS + DATA_BITS;
    localparam int FRAC_BITS    = 12;
    localparam int SUM_BITS     = 32;
    localparam int EXT_BITS     = 64;
    localparam int LANE_BITS    = 4;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] activation;
        logic [WORD_BITS-1:0]        packed_word;
        logic signed [DATA_BITS-1:0] scale;
        logic signed [DATA_BITS-1:0] zero;
        logic                        last_k;
    } t_in_item;

    typedef struct packed {
        logic [LANE_BITS-1:0]       lane;
        logic signed [SUM_BITS-1:0] sum;
        logic                       saturated;
        logic                       last;
    } t_out_item;

    // drain request from the lane array to the merge stage
    typedef struct packed {
        logic                 start;
        logic [LANE_BITS-1:0] last_lane;
    } t_drain_ctl;

endpackage

### hdl/glwde_lane.sv
// One lane: dequantize a code, multiply by the activation, saturating accumulate.
module glwde_lane
    import glwde_pkg::*;
#(
    parameter int ACC_BITS = ACC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [CODE_BITS-1:0]        i_code,
    input  logic signed [DATA_BITS-1:0] i_scale,
    input  logic signed [DATA_BITS-1:0] i_zero,
    input  logic signed [DATA_BITS-1:0] i_act,
    input  logic                        i_clr,
    output logic signed [ACC_BITS-1:0]  o_acc
);

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic                        r_v1, r_v2;
    logic signed [DQ_BITS-1:0]   r_w, n_w;
    logic signed [DATA_BITS-1:0] r_a1;
    logic signed [PROD_BITS-1:0] r_p, n_p;
    logic signed [ACC_BITS-1:0]  r_acc, n_acc;
    logic signed [DQ_MUL_BITS-1:0] mul_c;
    logic signed [ACC_BITS:0]    sum_c;

    always_comb begin
        mul_c = DQ_MUL_BITS'(signed'({1'b0, i_code})) * DQ_MUL_BITS'(i_scale);
        n_w   = DQ_BITS'(mul_c) + DQ_BITS'(i_zero);
        n_p   = PROD_BITS'(r_w) * PROD_BITS'(r_a1);
        sum_c = (ACC_BITS+1)'(r_acc) + (ACC_BITS+1)'(r_p);
        if (sum_c[ACC_BITS] != sum_c[ACC_BITS-1]) begin
            n_acc = sum_c[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            n_acc = sum_c[ACC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_en;
            r_v2 <= r_v1;
            priority if (i_clr) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= n_acc;
            end else begin
                r_acc <= r_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w  <= n_w;
        r_a1 <= i_act;
        r_p  <= n_p;
    end

    assign o_acc = r_acc;

endmodule

### hdl/glwde_merge.sv
// Merge stage: walks the lane sums in order, rounds, saturates and holds the output.
module glwde_merge
    import glwde_pkg::*;
#(
    parameter int LANES    = LANES_DEF,
    parameter int ACC_BITS = ACC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_drain_ctl                        i_ctl,
    input  logic [LANES-1:0][ACC_BITS-1:0]    i_acc,
    output logic                              o_done,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output t_out_item                         o_out_item
);

    localparam int IW = $clog2(LANES);
    localparam int RW = ACC_BITS - FRAC_BITS + 1;

    logic                  r_drain, n_drain;
    logic [IW-1:0]         r_idx, n_idx;
    logic [LANE_BITS-1:0]  r_last_lane, n_last_lane;
    logic                  r_ov, n_ov;
    t_out_item             r_out, n_out;

    logic                       ld;
    logic                       is_last;
    logic signed [ACC_BITS-1:0] acc_sel;
    logic signed [RW-1:0]       rnd;
    logic signed [EXT_BITS-1:0] wide;
    logic                       sat_hi, sat_lo;

    always_comb begin
        acc_sel = i_acc[r_idx];
        // round half up: floor(acc / 4096) plus the half bit
        rnd  = RW'(acc_sel >>> FRAC_BITS) + RW'(signed'({1'b0, acc_sel[FRAC_BITS-1]}));
        wide = EXT_BITS'(rnd);
        sat_hi = !wide[EXT_BITS-1] && (|wide[EXT_BITS-2:SUM_BITS-1]);
        sat_lo = wide[EXT_BITS-1] && !(&wide[EXT_BITS-2:SUM_BITS-1]);
        is_last = (LANE_BITS'(r_idx) == r_last_lane);
        ld      = r_drain && (!r_ov || !i_out_stall);

        n_drain     = r_drain;
        n_idx       = r_idx;
        n_last_lane = r_last_lane;
        n_ov        = r_ov;
        n_out       = r_out;

        if (i_ctl.start) begin
            n_drain     = 1'b1;
            n_idx       = '0;
            n_last_lane = i_ctl.last_lane;
        end
        if (ld) begin
            n_ov            = 1'b1;
            n_out.lane      = LANE_BITS'(r_idx);
            n_out.saturated = sat_hi || sat_lo;
            n_out.last      = is_last;
            priority if (sat_hi) begin
                n_out.sum = {1'b0, {(SUM_BITS-1){1'b1}}};
            end else if (sat_lo) begin
                n_out.sum = {1'b1, {(SUM_BITS-1){1'b0}}};
            end else begin
                n_out.sum = wide[SUM_BITS-1:0];
            end
            if (is_last) begin
                n_drain = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end else if (!i_out_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain     <= 1'b0;
            r_idx       <= '0;
            r_last_lane <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_drain     <= n_drain;
            r_idx       <= n_idx;
            r_last_lane <= n_last_lane;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done      = ld && is_last;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

endmodule

### hdl/grouped_lowbit_weight_dot_engine_unit.sv
// Grouped low-bit weight dot engine: lane array plus ordered result merge.
// Timing: after the item marked last_k transfers, the start flag passes r_s1, r_s2
// and r_s3 while the lane pipeline finishes, then the merge stage sets its drain flag
// and registers one result per cycle while the output does not stall. Within a block
// the input takes one item per cycle; after a last_k item it stalls until the last active lane drains.
// Reset (synchronous, active low) selects 4-bit codes and zeroes every accumulator.
module grouped_lowbit_weight_dot_engine_unit
    import glwde_pkg::*;
#(
    parameter int LANES    = LANES_DEF,
    parameter int ACC_BITS = ACC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic r_mode;
    logic r_busy, n_busy;
    logic r_s1, r_s2, r_s3;
    logic [LANE_BITS-1:0] r_ll1, r_ll2, r_ll3;

    logic                          take;
    logic                          done;
    logic [LANE_BITS-1:0]          last_lane;
    logic [LANES-1:0][CODE_BITS-1:0] code;
    logic [LANES-1:0]              en;
    logic [LANES-1:0][ACC_BITS-1:0] acc;
    t_drain_ctl                    ctl;

    assign take      = i_in_valid && !r_busy;
    assign last_lane = r_mode ? LANE_BITS'(CODES_WIDE - 1) : LANE_BITS'(LANES - 1);

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        if (i < CODES_WIDE) begin : g_wide
            assign code[i] = r_mode ? i_in_item.packed_word[4*i +: 4]
                                    : {2'b00, i_in_item.packed_word[2*i +: 2]};
            assign en[i]   = take;
        end else begin : g_narrow
            assign code[i] = {2'b00, i_in_item.packed_word[2*i +: 2]};
            assign en[i]   = take && !r_mode;
        end

        glwde_lane #(
            .ACC_BITS(ACC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en[i]),
            .i_code (code[i]),
            .i_scale(i_in_item.scale),
            .i_zero (i_in_item.zero),
            .i_act  (i_in_item.activation),
            .i_clr  (done),
            .o_acc  (acc[i])
        );
    end

    always_comb begin
        n_busy = r_busy;
        if (take && i_in_item.last_k) begin
            n_busy = 1'b1;
        end else if (done) begin
            n_busy = 1'b0;
        end
        ctl.start     = r_s3;
        ctl.last_lane = r_ll3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_busy <= 1'b0;
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_s3   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_busy <= n_busy;
            r_s1   <= take && i_in_item.last_k;
            r_s2   <= r_s1;
            r_s3   <= r_s2;
        end
    end

    // the last lane index travels with the last item through the lane pipeline
    always_ff @(posedge i_clk) begin
        r_ll1 <= last_lane;
        r_ll2 <= r_ll1;
        r_ll3 <= r_ll2;
    end

    glwde_merge #(
        .LANES   (LANES),
        .ACC_BITS(ACC_BITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_acc      (acc),
        .o_done     (done),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    assign o_in_stall = r_busy;

endmodule

### hdl/glwde_checker.sv
// Port-level checks for the dot engine, bound to the top level.
module glwde_checker
    import glwde_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output changed while stalled");

    // the input closes right after the transfer that ends a block
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.last_k |=> o_in_stall)
        else $error("input open after last_k transfer");

    // the input closes only because of a last_k transfer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && i_in_item.last_k))
        else $error("input stall without last_k");

    // results other than the final one appear only while the input is closed
    a_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> o_in_stall)
        else $error("partial block result with input open");

    // a clipped sum sits at a 32-bit limit
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.saturated |->
            (o_out_item.sum == {1'b0, {(SUM_BITS-1){1'b1}}}) ||
            (o_out_item.sum == {1'b1, {(SUM_BITS-1){1'b0}}}))
        else $error("saturated flag with unclipped sum");

endmodule

bind grouped_lowbit_weight_dot_engine_unit glwde_checker u_glwde_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_item  (i_in_item),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
